@@ rtl/i2cm_pkg.sv @@
`default_nettype none
package i2cm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] UNIT_TICKS_RST  = 16'd10;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

  // configuration register indexes
  localparam logic CFG_UNIT_TICKS  = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // raw op codes on the input stream
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ_ACK,
    CMD_READ_NACK
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_ST_C,
    PH_SP_A,
    PH_SP_B,
    PH_SP_C,
    PH_WR_D,
    PH_WR_H,
    PH_WR_L,
    PH_AK_R,
    PH_AK_S,
    PH_AK_W,
    PH_RD_L,
    PH_RD_H,
    PH_RA_D,
    PH_RA_H,
    PH_TS_A,
    PH_TS_B,
    PH_TS_C
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wr_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [15:0] unit_ticks;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       ack_missing;
    logic       done_res;
    logic [7:0] rd_data;
    logic       busy_res;
    logic       sda_release;
    logic       scl_level;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/i2cm_front.sv @@
`default_nettype none
module i2cm_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [2:0]          in_op,
  input  wire  [7:0]          in_wr_data,
  input  wire                 in_sda,
  output logic                item_valid,
  output i2cm_pkg::item_t     item,
  input  wire                 item_pop
);

  i2cm_pkg::item_t                      q_mem [i2cm_pkg::QUEUE_DEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [i2cm_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [i2cm_pkg::QCNT_W-1:0]          cnt_r, cnt_nxt;
  i2cm_pkg::item_t                      dec;
  logic                                 push;
  logic                                 pop;

  always_comb begin
    case (in_op)
      i2cm_pkg::OP_START:     dec.cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::OP_STOP:      dec.cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::OP_WRITE:     dec.cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::OP_READ_ACK:  dec.cmd = i2cm_pkg::CMD_READ_ACK;
      i2cm_pkg::OP_READ_NACK: dec.cmd = i2cm_pkg::CMD_READ_NACK;
      i2cm_pkg::OP_TICK:      dec.cmd = i2cm_pkg::CMD_NONE;
      default:                dec.cmd = i2cm_pkg::CMD_NONE;
    endcase
    dec.wr_data = in_wr_data;
    dec.sda_in  = in_sda;
  end

  assign in_ready   = (cnt_r != i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_mem[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_pop && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

@@ rtl/i2cm_engine.sv @@
`default_nettype none
module i2cm_engine (
  input  wire                 clk,
  input  wire                 rst_n,
  input  i2cm_pkg::cfg_t      cfg,
  input  wire                 item_valid,
  input  i2cm_pkg::item_t     item,
  output logic                item_pop,
  output logic                res_valid,
  output i2cm_pkg::result_t   res,
  input  wire                 res_ready
);

  i2cm_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]        bit_idx_r, bit_idx_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [15:0]       unit_cnt_r, unit_cnt_nxt;
  logic [15:0]       wait_cnt_r, wait_cnt_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              nack_r, nack_nxt;
  logic [7:0]        rd_r, rd_nxt;
  logic              miss_r, miss_nxt;
  logic              done;
  logic              res_valid_r, res_valid_nxt;
  i2cm_pkg::result_t res_r;

  logic [15:0]       eff_units;
  logic [15:0]       limit;
  logic [15:0]       wait_inc;
  logic [3:0]        bit_inc;
  logic [7:0]        shift_l1;
  logic              step;

  assign eff_units = (cfg.unit_ticks == '0) ? 16'd1 : cfg.unit_ticks;
  assign limit     = (cfg.ack_timeout == '0) ? 16'd1 : cfg.ack_timeout;
  assign wait_inc  = (wait_cnt_r == 16'hFFFF) ? wait_cnt_r : wait_cnt_r + 16'd1;
  assign bit_inc   = bit_idx_r + 4'd1;
  assign shift_l1  = {shift_r[6:0], 1'b0};

  // one tick of the bit engine per item; output register frees on transfer
  assign step     = item_valid && (!res_valid_r || res_ready);
  assign item_pop = step;

  always_comb begin
    phase_nxt    = phase_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    unit_cnt_nxt = unit_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    nack_nxt     = nack_r;
    rd_nxt       = rd_r;
    miss_nxt     = miss_r;
    done         = 1'b0;

    if (phase_r == i2cm_pkg::PH_IDLE) begin
      if (item.cmd != i2cm_pkg::CMD_NONE) begin
        miss_nxt     = 1'b0;
        unit_cnt_nxt = eff_units;
      end
      case (item.cmd)
        i2cm_pkg::CMD_START: begin
          phase_nxt = i2cm_pkg::PH_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1;
          wait_cnt_nxt = 16'd4;
        end
        i2cm_pkg::CMD_STOP: begin
          phase_nxt = i2cm_pkg::PH_SP_A; scl_nxt = 1'b0; sda_nxt = 1'b0;
          wait_cnt_nxt = 16'd4;
        end
        i2cm_pkg::CMD_WRITE: begin
          shift_nxt = item.wr_data; bit_idx_nxt = '0;
          phase_nxt = i2cm_pkg::PH_WR_D; scl_nxt = 1'b0; sda_nxt = item.wr_data[7];
          wait_cnt_nxt = 16'd2;
        end
        i2cm_pkg::CMD_READ_ACK, i2cm_pkg::CMD_READ_NACK: begin
          nack_nxt  = (item.cmd == i2cm_pkg::CMD_READ_NACK);
          shift_nxt = '0; bit_idx_nxt = '0;
          phase_nxt = i2cm_pkg::PH_RD_L; scl_nxt = 1'b0; sda_nxt = 1'b1;
          wait_cnt_nxt = 16'd2;
        end
        default: ;
      endcase
    end else if (phase_r == i2cm_pkg::PH_AK_W) begin
      if (!item.sda_in) begin
        scl_nxt   = 1'b0;
        phase_nxt = i2cm_pkg::PH_IDLE;
        done      = 1'b1;
      end else begin
        wait_cnt_nxt = wait_inc;
        if (wait_inc >= limit) begin
          // ack timeout: run a stop sequence
          phase_nxt = i2cm_pkg::PH_TS_A; scl_nxt = 1'b0; sda_nxt = 1'b0;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd4;
        end
      end
    end else if (unit_cnt_r > 16'd1) begin
      unit_cnt_nxt = unit_cnt_r - 16'd1;
    end else if (wait_cnt_r > 16'd1) begin
      wait_cnt_nxt = wait_cnt_r - 16'd1;
      unit_cnt_nxt = eff_units;
    end else begin
      // segment over: move on; a new segment reloads both counters
      wait_cnt_nxt = '0;
      unit_cnt_nxt = '0;
      case (phase_r)
        i2cm_pkg::PH_ST_A: begin
          phase_nxt = i2cm_pkg::PH_ST_B; scl_nxt = 1'b1; sda_nxt = 1'b0;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd4;
        end
        i2cm_pkg::PH_ST_B: begin
          phase_nxt = i2cm_pkg::PH_ST_C; scl_nxt = 1'b0; sda_nxt = 1'b0;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd2;
        end
        i2cm_pkg::PH_SP_A, i2cm_pkg::PH_TS_A: begin
          phase_nxt = (phase_r == i2cm_pkg::PH_SP_A) ? i2cm_pkg::PH_SP_B :
                      i2cm_pkg::PH_TS_B;
          scl_nxt = 1'b1; sda_nxt = 1'b0;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd4;
        end
        i2cm_pkg::PH_SP_B, i2cm_pkg::PH_TS_B: begin
          phase_nxt = (phase_r == i2cm_pkg::PH_SP_B) ? i2cm_pkg::PH_SP_C :
                      i2cm_pkg::PH_TS_C;
          scl_nxt = 1'b1; sda_nxt = 1'b1;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd4;
        end
        i2cm_pkg::PH_ST_C, i2cm_pkg::PH_SP_C: begin
          phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        i2cm_pkg::PH_TS_C: begin
          miss_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        i2cm_pkg::PH_WR_D: begin
          phase_nxt = i2cm_pkg::PH_WR_H; scl_nxt = 1'b1;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd2;
        end
        i2cm_pkg::PH_WR_H: begin
          phase_nxt = i2cm_pkg::PH_WR_L; scl_nxt = 1'b0;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd2;
        end
        i2cm_pkg::PH_WR_L: begin
          shift_nxt    = shift_l1;
          bit_idx_nxt  = bit_inc;
          scl_nxt      = 1'b0;
          unit_cnt_nxt = eff_units;
          if (bit_inc >= 4'd8) begin
            phase_nxt = i2cm_pkg::PH_AK_R; sda_nxt = 1'b1; wait_cnt_nxt = 16'd1;
          end else begin
            phase_nxt = i2cm_pkg::PH_WR_D; sda_nxt = shift_l1[7]; wait_cnt_nxt = 16'd2;
          end
        end
        i2cm_pkg::PH_AK_R: begin
          phase_nxt = i2cm_pkg::PH_AK_S; scl_nxt = 1'b1; sda_nxt = 1'b1;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd1;
        end
        i2cm_pkg::PH_AK_S: begin
          phase_nxt = i2cm_pkg::PH_AK_W;
        end
        i2cm_pkg::PH_RD_L: begin
          // sample SDA as SCL rises
          shift_nxt = {shift_r[6:0], item.sda_in};
          phase_nxt = i2cm_pkg::PH_RD_H; scl_nxt = 1'b1; sda_nxt = 1'b1;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd1;
        end
        i2cm_pkg::PH_RD_H: begin
          bit_idx_nxt  = bit_inc;
          scl_nxt      = 1'b0;
          unit_cnt_nxt = eff_units;
          wait_cnt_nxt = 16'd2;
          if (bit_inc >= 4'd8) begin
            rd_nxt = shift_r; phase_nxt = i2cm_pkg::PH_RA_D; sda_nxt = nack_r;
          end else begin
            phase_nxt = i2cm_pkg::PH_RD_L; sda_nxt = 1'b1;
          end
        end
        i2cm_pkg::PH_RA_D: begin
          phase_nxt = i2cm_pkg::PH_RA_H; scl_nxt = 1'b1;
          unit_cnt_nxt = eff_units; wait_cnt_nxt = 16'd2;
        end
        i2cm_pkg::PH_RA_H: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        default: phase_nxt = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (step) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cm_pkg::PH_IDLE;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      unit_cnt_r  <= '0;
      wait_cnt_r  <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      nack_r      <= 1'b0;
      rd_r        <= '0;
      miss_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (step) begin
        phase_r    <= phase_nxt;
        bit_idx_r  <= bit_idx_nxt;
        shift_r    <= shift_nxt;
        unit_cnt_r <= unit_cnt_nxt;
        wait_cnt_r <= wait_cnt_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
        nack_r     <= nack_nxt;
        rd_r       <= rd_nxt;
        miss_r     <= miss_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r.scl_level   <= scl_nxt;
      res_r.sda_release <= sda_nxt;
      res_r.busy_res    <= (phase_nxt != i2cm_pkg::PH_IDLE);
      res_r.rd_data     <= rd_nxt;
      res_r.done_res    <= done;
      res_r.ack_missing <= miss_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

@@ rtl/i2c_master_bit_engine_top.sv @@
// I2C master bit engine. Every input transfer is one timing tick: it carries
// an op code (in_tuser), the byte to send and the sampled SDA level, and
// produces exactly one result transfer with the SCL/SDA drive levels after
// that tick, busy, the last read byte, a done pulse and the ack-missing flag.
// Commands other than tick-only are ignored while busy. The block takes one
// item per cycle while out_tready does not stall it; the bit engine advances
// its phase, bit and unit counters once per item. An item passes through the
// two-entry command queue and then the output register. unit_ticks and
// ack_timeout reset to 10 and 250; a zero in either counts as one. Write them
// only while no items are in flight.
`default_nettype none
module i2c_master_bit_engine_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // wr_data[7:0], sda_in[8], zero[15:9]
  input  wire  [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // scl_level, sda_release, busy_res, rd_data[7:0],
                                  // done_res, ack_missing, zero[15:13]
  input  wire         cfg_we,
  input  wire         cfg_addr,
  input  wire  [15:0] cfg_wdata
);

  i2cm_pkg::cfg_t    cfg_r;
  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;
  logic              item_valid;
  logic              item_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks  <= i2cm_pkg::UNIT_TICKS_RST;
      cfg_r.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        i2cm_pkg::CFG_UNIT_TICKS:  cfg_r.unit_ticks  <= cfg_wdata;
        i2cm_pkg::CFG_ACK_TIMEOUT: cfg_r.ack_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_wr_data (in_tdata[7:0]),
    .in_sda     (in_tdata[8]),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  i2cm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  assign out_tdata = {3'b000, res.ack_missing, res.done_res, res.rd_data,
                      res.busy_res, res.sda_release, res.scl_level};

endmodule
`default_nettype wire
